// ===== hdl/seit_pkg.sv =====
// Shared types and constants for the sequenced event input tracker.
// Depends on nothing; every other file in hdl imports it.
`default_nettype none

package seit_pkg;

    // Operation codes carried by each input beat
    typedef enum logic [1:0] {
        OP_STAGE = 2'd0,
        OP_EVENT = 2'd1,
        OP_FRAME = 2'd2,
        OP_LATCH = 2'd3
    } t_op;

    // Event kinds of a sequenced event; the remaining codes are invalid
    typedef enum logic [2:0] {
        KIND_APPLY   = 3'd0,
        KIND_PLACE   = 3'd1,
        KIND_REMOVE  = 3'd2,
        KIND_ABANDON = 3'd3,
        KIND_RESET   = 3'd4
    } t_kind;

    // Result status codes
    typedef enum logic [1:0] {
        ST_ACCEPTED  = 2'd0,
        ST_DUPLICATE = 2'd1,
        ST_STALE     = 2'd2,
        ST_INVALID   = 2'd3
    } t_status;

    localparam int unsigned SEQ_W = 16;
    localparam int unsigned RND_W = 16;
    localparam int unsigned WORD_W = 32;

    // Serial-number window: a newer sequence lies below this distance
    localparam logic [SEQ_W-1:0] NEWER_LIMIT = 16'h8000;

    // Tracking state that is independent of the configuration width
    typedef struct packed {
        logic             pending;
        logic             active;
        logic             present;
        logic             latched;
        logic             seen;
        logic [RND_W-1:0] round;
        logic [SEQ_W-1:0] last_seq;
    } t_flags;

    // Configuration register loads requested by the decision logic
    typedef struct packed {
        logic load_staged;
        logic load_pending;
        logic load_active;
    } t_cfg_ctl;

endpackage

`default_nettype wire

// ===== hdl/seit_if.sv =====
// Valid/ready channel interfaces for event beats and result beats.
// Depends on seit_pkg for the field widths.
`default_nettype none

interface seit_evt_if import seit_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [1:0]        op;
    logic [2:0]        event_kind;
    logic [SEQ_W-1:0]  sequence_number;
    logic [RND_W-1:0]  round_number_in;
    logic [WORD_W-1:0] config_word;

    modport source (
        output valid, op, event_kind, sequence_number, round_number_in, config_word,
        input  ready
    );
    modport sink (
        input  valid, op, event_kind, sequence_number, round_number_in, config_word,
        output ready
    );
endinterface

interface seit_res_if import seit_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [1:0]        status;
    logic              ack_valid;
    logic [SEQ_W-1:0]  acked_sequence;
    logic [RND_W-1:0]  current_round;
    logic [WORD_W-1:0] active_config_word;
    logic              config_is_active;
    logic              config_is_pending;
    logic              object_is_present;
    logic              result_is_latched;

    modport source (
        output valid, status, ack_valid, acked_sequence, current_round,
               active_config_word, config_is_active, config_is_pending,
               object_is_present, result_is_latched,
        input  ready
    );
    modport sink (
        input  valid, status, ack_valid, acked_sequence, current_round,
               active_config_word, config_is_active, config_is_pending,
               object_is_present, result_is_latched,
        output ready
    );
endinterface

`default_nettype wire

// ===== hdl/seit_core.sv =====
// Decision logic of the tracker: sequence check, event preconditions and
// next tracking state for one beat. Purely combinational; depends on seit_pkg.
`default_nettype none

module seit_core
    import seit_pkg::*;
(
    input  wire logic [1:0]       i_op,
    input  wire logic [2:0]       i_kind,
    input  wire logic [SEQ_W-1:0] i_seq,
    input  wire logic [RND_W-1:0] i_rnd,
    input  wire t_flags           i_state,
    output t_flags                o_state,
    output t_cfg_ctl              o_ctl,
    output t_status               o_status,
    output logic                  o_ack
);

    logic [SEQ_W-1:0] seq_diff;
    logic             seq_newer;
    logic             seq_dup;

    // Serial-number compare against the last accepted sequence
    assign seq_diff  = i_seq - i_state.last_seq;
    assign seq_newer = (seq_diff != '0) && (seq_diff < NEWER_LIMIT);
    assign seq_dup   = (seq_diff == '0);

    always_comb begin
        o_state  = i_state;
        o_ctl    = '0;
        o_status = ST_ACCEPTED;
        o_ack    = 1'b0;

        case (i_op)
            OP_STAGE: begin
                o_ctl.load_staged = 1'b1;
            end
            OP_EVENT: begin
                if (i_state.seen && seq_dup) begin
                    o_status = ST_DUPLICATE;
                end else if (i_state.seen && !seq_newer) begin
                    o_status = ST_STALE;
                end else begin
                    // Apply the event kind when its precondition holds
                    case (i_kind)
                        KIND_APPLY: begin
                            o_ctl.load_pending = 1'b1;
                            o_state.pending    = 1'b1;
                        end
                        KIND_PLACE: begin
                            if (!i_state.active || i_state.present) begin
                                o_status = ST_INVALID;
                            end else begin
                                o_state.present = 1'b1;
                                o_state.latched = 1'b0;
                                o_state.round   = i_state.round + 1'b1;
                            end
                        end
                        KIND_REMOVE, KIND_ABANDON: begin
                            if (!i_state.present) begin
                                o_status = ST_INVALID;
                            end else begin
                                o_state.present = 1'b0;
                                o_state.latched = 1'b0;
                            end
                        end
                        KIND_RESET: begin
                            o_state.pending = 1'b0;
                            o_state.active  = 1'b0;
                            o_state.present = 1'b0;
                            o_state.latched = 1'b0;
                        end
                        default: begin
                            o_status = ST_INVALID;
                        end
                    endcase
                    // Advance the sequence only on an accepted event
                    if (o_status == ST_ACCEPTED) begin
                        o_state.last_seq = i_seq;
                        o_state.seen     = 1'b1;
                        o_ack            = 1'b1;
                    end
                end
            end
            OP_FRAME: begin
                if (!i_state.pending) begin
                    o_status = ST_INVALID;
                end else begin
                    o_ctl.load_active = 1'b1;
                    o_state.pending   = 1'b0;
                    o_state.active    = 1'b1;
                end
            end
            OP_LATCH: begin
                if (!i_state.present || i_state.latched || (i_state.round != i_rnd)) begin
                    o_status = ST_INVALID;
                end else begin
                    o_state.latched = 1'b1;
                end
            end
            default: begin
                o_status = ST_INVALID;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== hdl/sequenced_event_input_tracker.sv =====
// Top level of the sequenced event input tracker: input register, decision
// logic, result register. Depends on seit_pkg, seit_if.sv and seit_core.
//
// Usage:
//   i_evt carries one beat per host operation: stage a configuration word,
//   a sequenced event, a frame boundary, or a result latch. o_res returns
//   exactly one result beat per input beat, in order, holding the status,
//   the acknowledgement and the tracking state after that beat.
//   Path: an accepted beat waits in the input register, is decided, and is
//   written to the result register, from which o_res presents it.
//   Throughput: one beat per cycle unless o_res stalls; the next beat is
//   taken while a result waits, since input and result registers are separate stages.
//   Stall: when o_res.ready is low the result holds, the input register
//   fills, and i_evt.ready drops until the result is taken.
//   Reset (i_rst_n low, synchronous): clears all flags, the round counter,
//   the sequence tracking and the configuration words; no beat is pending.
//   CONFIG_WIDTH bits of config_word are kept; active_config_word shows the
//   low 32 bits of the active configuration, zero-extended when narrower.
`default_nettype none

module sequenced_event_input_tracker
    import seit_pkg::*;
#(
    parameter int unsigned CONFIG_WIDTH = 32
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    seit_evt_if.sink   i_evt,
    seit_res_if.source o_res
);

    // Input register
    logic                    r_in_valid;
    logic [1:0]              r_in_op;
    logic [2:0]              r_in_kind;
    logic [SEQ_W-1:0]        r_in_seq;
    logic [RND_W-1:0]        r_in_rnd;
    logic [WORD_W-1:0]       r_in_word;

    // Tracking state and configuration words
    t_flags                  r_flags;
    t_flags                  n_flags;
    logic [CONFIG_WIDTH-1:0] r_staged;
    logic [CONFIG_WIDTH-1:0] r_pending;
    logic [CONFIG_WIDTH-1:0] r_active;
    logic [CONFIG_WIDTH-1:0] n_active;

    // Result register
    logic                    r_out_valid;
    t_status                 r_out_status;
    logic                    r_out_ack;
    logic [SEQ_W-1:0]        r_out_acked;
    t_flags                  r_out_flags;
    logic [WORD_W-1:0]       r_out_word;

    t_cfg_ctl                dec_ctl;
    t_status                 dec_status;
    logic                    dec_ack;
    logic                    advance;
    logic                    in_take;

    // Move a beat from the input register into the result register
    assign advance = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_evt.ready = !r_in_valid || advance;
    assign in_take = i_evt.valid && i_evt.ready;

    seit_core u_core (
        .i_op     (r_in_op),
        .i_kind   (r_in_kind),
        .i_seq    (r_in_seq),
        .i_rnd    (r_in_rnd),
        .i_state  (r_flags),
        .o_state  (n_flags),
        .o_ctl    (dec_ctl),
        .o_status (dec_status),
        .o_ack    (dec_ack)
    );

    assign n_active = dec_ctl.load_active ? r_pending : r_active;

    // Capture the input beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_evt.ready) begin
            r_in_valid <= i_evt.valid;
        end
        if (in_take) begin
            r_in_op   <= i_evt.op;
            r_in_kind <= i_evt.event_kind;
            r_in_seq  <= i_evt.sequence_number;
            r_in_rnd  <= i_evt.round_number_in;
            r_in_word <= i_evt.config_word;
        end
    end

    // Update tracking state and configuration words
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags   <= '0;
            r_staged  <= '0;
            r_pending <= '0;
            r_active  <= '0;
        end else if (advance) begin
            r_flags  <= n_flags;
            r_active <= n_active;
            if (dec_ctl.load_staged) begin
                r_staged <= CONFIG_WIDTH'(r_in_word);
            end
            if (dec_ctl.load_pending) begin
                r_pending <= r_staged;
            end
        end
    end

    // Hold the result beat until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
        if (advance) begin
            r_out_status <= dec_status;
            r_out_ack    <= dec_ack;
            r_out_acked  <= dec_ack ? r_in_seq : '0;
            r_out_flags  <= n_flags;
            r_out_word   <= WORD_W'(n_active);
        end
    end

    assign o_res.valid              = r_out_valid;
    assign o_res.status             = r_out_status;
    assign o_res.ack_valid          = r_out_ack;
    assign o_res.acked_sequence     = r_out_acked;
    assign o_res.current_round      = r_out_flags.round;
    assign o_res.active_config_word = r_out_word;
    assign o_res.config_is_active   = r_out_flags.active;
    assign o_res.config_is_pending  = r_out_flags.pending;
    assign o_res.object_is_present  = r_out_flags.present;
    assign o_res.result_is_latched  = r_out_flags.latched;

    // A latched result always belongs to a placed object
    a_latched_needs_object: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_flags.latched |-> r_flags.present)
        else $error("latched flag set without an object present");

    // An acknowledgement only comes with an accepted status
    a_ack_means_accepted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_ack) |-> (r_out_status == ST_ACCEPTED))
        else $error("acknowledged beat without accepted status");

    // The round counter only holds or steps by one
    a_round_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n |=> ($stable(r_flags.round)
                     || (r_flags.round == RND_W'($past(r_flags.round) + 1'b1))))
        else $error("round counter jumped");

    // Tracking state changes only when a beat advances
    a_state_moves_on_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !advance |=> $stable(r_flags))
        else $error("tracking state changed without a beat");

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
// Self-checking bench for the sequenced event input tracker: directed and random host
// beats, a beat-level prediction of every result beat, random back-pressure on both sides.
// Depends on seit_pkg, the channel interfaces in seit_if.sv and the top level of the block.

module testbench;
    import seit_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned RANDOM_BEATS     = 1600;
    localparam int unsigned TAIL_BEATS       = 150;
    localparam int unsigned LONG_HOLD_START  = 300;
    localparam int unsigned LONG_HOLD_CYCLES = 200;
    localparam int unsigned SETTLE_CYCLES    = 8;
    localparam int unsigned TIMEOUT_NS       = 5_000_000;

    // Event kind codes the block must refuse
    localparam logic [2:0] KIND_UNUSED_LO  = 3'd5;
    localparam logic [2:0] KIND_UNUSED_MID = 3'd6;
    localparam logic [2:0] KIND_UNUSED_HI  = 3'd7;

    typedef struct {
        t_op               op;
        logic [2:0]        kind;
        logic [SEQ_W-1:0]  seq;
        logic [RND_W-1:0]  rnd;
        logic [WORD_W-1:0] word;
        bit                drain_first;
    } host_beat_t;

    typedef struct {
        logic [WORD_W-1:0] staged;
        logic [WORD_W-1:0] pending_word;
        logic [WORD_W-1:0] active_word;
        logic              pend;
        logic              act;
        logic              present;
        logic              latched;
        logic              seen;
        logic [RND_W-1:0]  round;
        logic [SEQ_W-1:0]  last_seq;
    } tracker_t;

    typedef struct {
        t_status           status;
        logic              ack;
        logic [SEQ_W-1:0]  acked;
        logic [RND_W-1:0]  round;
        logic [WORD_W-1:0] cfg;
        logic              act;
        logic              pend;
        logic              present;
        logic              latched;
    } tracker_res_t;

    logic clk = 1'b0;
    logic rst_n;

    seit_evt_if evt_ch ();
    seit_res_if res_ch ();

    sequenced_event_input_tracker dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_evt   (evt_ch),
        .o_res   (res_ch)
    );

    host_beat_t   beat_q[$];
    tracker_res_t expect_q[$];
    tracker_t     plan_state;
    tracker_t     model_state;
    int unsigned  total_beats;
    int unsigned  beats_in;
    int unsigned  fail_count;
    bit           evt_taken;
    int unsigned  send_gap;
    int unsigned  recv_gap;
    int unsigned  long_hold;
    bit           long_hold_done;

    // Advance the tracker state by one beat and return the result beat it gives
    function automatic tracker_res_t track_step(inout tracker_t s, input host_beat_t b);
        tracker_res_t     r;
        t_status          st;
        logic [SEQ_W-1:0] seq_gap;
        st = ST_ACCEPTED;
        r.ack = 1'b0;
        r.acked = '0;
        case (b.op)
            OP_STAGE: s.staged = b.word;
            OP_EVENT: begin
                seq_gap = b.seq - s.last_seq;
                if (s.seen && b.seq == s.last_seq) begin
                    st = ST_DUPLICATE;
                end else if (s.seen && seq_gap >= NEWER_LIMIT) begin
                    st = ST_STALE;
                end else begin
                    case (b.kind)
                        KIND_APPLY: begin
                            s.pending_word = s.staged;
                            s.pend = 1'b1;
                        end
                        KIND_PLACE: begin
                            if (!s.act || s.present) begin
                                st = ST_INVALID;
                            end else begin
                                s.present = 1'b1;
                                s.latched = 1'b0;
                                s.round = s.round + 1'b1;
                            end
                        end
                        KIND_REMOVE, KIND_ABANDON: begin
                            if (!s.present) begin
                                st = ST_INVALID;
                            end else begin
                                s.present = 1'b0;
                                s.latched = 1'b0;
                            end
                        end
                        KIND_RESET: begin
                            s.pend = 1'b0;
                            s.act = 1'b0;
                            s.present = 1'b0;
                            s.latched = 1'b0;
                        end
                        default: st = ST_INVALID;
                    endcase
                    // Advance the sequence only on an applied event
                    if (st == ST_ACCEPTED) begin
                        s.last_seq = b.seq;
                        s.seen = 1'b1;
                        r.ack = 1'b1;
                        r.acked = b.seq;
                    end
                end
            end
            OP_FRAME: begin
                if (!s.pend) begin
                    st = ST_INVALID;
                end else begin
                    s.active_word = s.pending_word;
                    s.pend = 1'b0;
                    s.act = 1'b1;
                end
            end
            default: begin
                if (!s.present || s.latched || s.round != b.rnd) begin
                    st = ST_INVALID;
                end else begin
                    s.latched = 1'b1;
                end
            end
        endcase
        r.status = st;
        r.round = s.round;
        r.cfg = s.active_word;
        r.act = s.act;
        r.pend = s.pend;
        r.present = s.present;
        r.latched = s.latched;
        return r;
    endfunction

    // Sequence number around the last accepted one: mostly newer, some repeats and stale ones
    function automatic logic [SEQ_W-1:0] pick_seq(input tracker_t s);
        logic [SEQ_W-1:0] base;
        base = s.last_seq;
        case ($urandom_range(0, 19))
            0: return base;
            1: return base - SEQ_W'($urandom_range(1, 64));
            2: return base + NEWER_LIMIT + SEQ_W'($urandom_range(0, 16'h7FFF));
            3: return SEQ_W'($urandom);
            4: return base + (NEWER_LIMIT - 1'b1);
            default: return base + SEQ_W'($urandom_range(1, 40));
        endcase
    endfunction

    function automatic logic [WORD_W-1:0] pick_word();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return $urandom;
        endcase
    endfunction

    // Append one beat and keep the planning copy of the state in step
    task automatic queue_beat(input t_op op, input logic [2:0] kind,
                              input logic [SEQ_W-1:0] seq, input logic [RND_W-1:0] rnd,
                              input logic [WORD_W-1:0] word);
        host_beat_t b;
        b.op = op;
        b.kind = kind;
        b.seq = seq;
        b.rnd = rnd;
        b.word = word;
        b.drain_first = 1'b0;
        void'(track_step(plan_state, b));
        beat_q.push_back(b);
    endtask

    task automatic check_field(input string name, input logic [WORD_W-1:0] got,
                               input logic [WORD_W-1:0] want);
        if (got !== want) begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
            fail_count++;
        end
    endtask

    // Clock
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Monitor: check result beats, predict for accepted host beats
    always @(posedge clk) begin
        tracker_res_t want;
        host_beat_t   b;
        evt_taken = 1'b0;
        if (rst_n) begin
            if (res_ch.valid && res_ch.ready) begin
                if (expect_q.size() == 0) begin
                    $error("result beat with no expectation waiting");
                    fail_count++;
                end else begin
                    want = expect_q.pop_front();
                    check_field("status", res_ch.status, want.status);
                    check_field("ack_valid", res_ch.ack_valid, want.ack);
                    check_field("acked_sequence", res_ch.acked_sequence, want.acked);
                    check_field("current_round", res_ch.current_round, want.round);
                    check_field("active_config_word", res_ch.active_config_word, want.cfg);
                    check_field("config_is_active", res_ch.config_is_active, want.act);
                    check_field("config_is_pending", res_ch.config_is_pending, want.pend);
                    check_field("object_is_present", res_ch.object_is_present, want.present);
                    check_field("result_is_latched", res_ch.result_is_latched, want.latched);
                end
            end
            if (evt_ch.valid && evt_ch.ready) begin
                b.op = t_op'(evt_ch.op);
                b.kind = evt_ch.event_kind;
                b.seq = evt_ch.sequence_number;
                b.rnd = evt_ch.round_number_in;
                b.word = evt_ch.config_word;
                b.drain_first = 1'b0;
                expect_q.push_back(track_step(model_state, b));
                beats_in++;
                evt_taken = 1'b1;
            end
        end
    end

    // Driver: offer queued beats, hold each until taken, idle in bursts
    always @(negedge clk) begin
        host_beat_t nb;
        if (rst_n && (!evt_ch.valid || evt_taken)) begin
            if (send_gap != 0) begin
                send_gap--;
                evt_ch.valid <= 1'b0;
            end else if (beat_q.size() == 0
                         || (beat_q[0].drain_first && expect_q.size() != 0)) begin
                evt_ch.valid <= 1'b0;
            end else begin
                nb = beat_q.pop_front();
                evt_ch.valid           <= 1'b1;
                evt_ch.op              <= nb.op;
                evt_ch.event_kind      <= nb.kind;
                evt_ch.sequence_number <= nb.seq;
                evt_ch.round_number_in <= nb.rnd;
                evt_ch.config_word     <= nb.word;
                if (beats_in + TAIL_BEATS < total_beats && $urandom_range(0, 5) == 0)
                    send_gap = $urandom_range(1, 9);
            end
        end
    end

    // Receiver: random stalls, plus one long hold so the block backs up
    always @(negedge clk) begin
        if (!rst_n) begin
            res_ch.ready <= 1'b0;
        end else if (long_hold != 0) begin
            long_hold--;
            res_ch.ready <= 1'b0;
        end else if (!long_hold_done && beats_in >= LONG_HOLD_START) begin
            long_hold_done = 1'b1;
            long_hold = LONG_HOLD_CYCLES - 1;
            res_ch.ready <= 1'b0;
        end else if (recv_gap != 0) begin
            recv_gap--;
            res_ch.ready <= 1'b0;
        end else begin
            res_ch.ready <= 1'b1;
            if (beats_in + TAIL_BEATS < total_beats && $urandom_range(0, 5) == 0)
                recv_gap = $urandom_range(1, 9);
        end
    end

    // Stimulus, reset and end of run
    initial begin
        int unsigned       pick;
        t_op               op;
        logic [2:0]        kind;
        logic [SEQ_W-1:0]  seq;
        logic [RND_W-1:0]  rnd;
        logic [WORD_W-1:0] word;

        rst_n = 1'b0;
        evt_ch.valid = 1'b0;
        evt_ch.op = OP_STAGE;
        evt_ch.event_kind = KIND_APPLY;
        evt_ch.sequence_number = '0;
        evt_ch.round_number_in = '0;
        evt_ch.config_word = '0;
        res_ch.ready = 1'b0;
        plan_state = '{default: '0};
        model_state = '{default: '0};

        // Directed: refusals from the empty state, then the sequence window edges and every event kind
        queue_beat(OP_FRAME, KIND_APPLY, 16'h0000, 16'hFFFF, 32'h0000_0000);
        queue_beat(OP_LATCH, KIND_APPLY, 16'h0000, 16'h0000, 32'h0000_0000);
        queue_beat(OP_EVENT, KIND_PLACE, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
        queue_beat(OP_EVENT, KIND_UNUSED_LO, 16'h1234, 16'h0000, 32'h0000_0000);
        queue_beat(OP_EVENT, KIND_UNUSED_MID, 16'h1234, 16'h0000, 32'h0000_0000);
        queue_beat(OP_EVENT, KIND_UNUSED_HI, 16'h1234, 16'h0000, 32'h0000_0000);
        queue_beat(OP_STAGE, KIND_UNUSED_HI, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
        queue_beat(OP_EVENT, KIND_APPLY, 16'h0000, 16'h0000, 32'h0000_0000);
        queue_beat(OP_EVENT, KIND_APPLY, 16'h0000, 16'h0000, 32'h0000_0000);
        queue_beat(OP_FRAME, KIND_APPLY, 16'h0000, 16'h0000, 32'h0000_0000);
        queue_beat(OP_EVENT, KIND_REMOVE, 16'h0001, 16'h0000, 32'h0000_0000);
        queue_beat(OP_EVENT, KIND_PLACE, 16'h7FFF, 16'h0000, 32'h0000_0000);
        queue_beat(OP_EVENT, KIND_PLACE, 16'hFFFF, 16'h0000, 32'h0000_0000);
        queue_beat(OP_EVENT, KIND_PLACE, 16'h8000, 16'h0000, 32'h0000_0000);
        queue_beat(OP_LATCH, KIND_APPLY, 16'h0000, 16'h0000, 32'h0000_0000);
        queue_beat(OP_LATCH, KIND_APPLY, 16'h0000, 16'h0001, 32'h0000_0000);
        queue_beat(OP_LATCH, KIND_APPLY, 16'h0000, 16'h0001, 32'h0000_0000);
        queue_beat(OP_EVENT, KIND_REMOVE, 16'h8000, 16'h0000, 32'h0000_0000);
        queue_beat(OP_EVENT, KIND_PLACE, 16'hFFFF, 16'h0000, 32'h0000_0000);
        queue_beat(OP_EVENT, KIND_ABANDON, 16'h0000, 16'h0000, 32'h0000_0000);
        queue_beat(OP_EVENT, KIND_RESET, 16'h0001, 16'h0000, 32'h0000_0000);
        queue_beat(OP_STAGE, KIND_APPLY, 16'h0000, 16'h0000, 32'h0000_0000);
        queue_beat(OP_FRAME, KIND_APPLY, 16'h0000, 16'h0000, 32'h0000_0000);
        queue_beat(OP_EVENT, KIND_APPLY, 16'h0000, 16'h0000, 32'h0000_0000);
        queue_beat(OP_EVENT, KIND_APPLY, 16'h0002, 16'h0000, 32'h0000_0000);
        queue_beat(OP_FRAME, KIND_APPLY, 16'h0000, 16'h0000, 32'h0000_0000);

        // Random: mostly well-formed session flow, some noise and broken order
        for (int n = 0; n < RANDOM_BEATS; n++) begin
            pick = $urandom_range(0, 99);
            op = OP_EVENT;
            kind = 3'($urandom_range(0, 7));
            seq = SEQ_W'($urandom);
            rnd = RND_W'($urandom);
            word = pick_word();
            if (pick < 10) begin
                op = t_op'($urandom_range(0, 3));
                if ($urandom_range(0, 1) == 1)
                    seq = pick_seq(plan_state);
                if ($urandom_range(0, 1) == 1)
                    rnd = plan_state.round;
            end else begin
                if (plan_state.pend && pick < 70) begin
                    op = OP_FRAME;
                end else if (!plan_state.act) begin
                    if (pick < 50)
                        op = OP_STAGE;
                    else
                        kind = KIND_APPLY;
                end else if (!plan_state.present) begin
                    if (pick < 65)
                        kind = KIND_PLACE;
                    else if (pick < 78)
                        op = OP_STAGE;
                    else if (pick < 90)
                        kind = KIND_APPLY;
                    else
                        kind = KIND_RESET;
                end else if (!plan_state.latched) begin
                    if (pick < 75) begin
                        op = OP_LATCH;
                        if (pick < 68)
                            rnd = plan_state.round;
                    end else begin
                        kind = ($urandom_range(0, 1) == 1) ? KIND_REMOVE : KIND_ABANDON;
                    end
                end else begin
                    if (pick < 80) begin
                        kind = ($urandom_range(0, 1) == 1) ? KIND_REMOVE : KIND_ABANDON;
                    end else if (pick < 90) begin
                        op = OP_LATCH;
                        rnd = plan_state.round;
                    end else begin
                        kind = KIND_RESET;
                    end
                end
                if (op == OP_EVENT)
                    seq = pick_seq(plan_state);
            end
            queue_beat(op, kind, seq, rnd, word);
            // Hold the sender here until every result so far is back
            if (n == 500 || n == 1100)
                beat_q[beat_q.size() - 1].drain_first = 1'b1;
        end
        total_beats = beat_q.size();

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (beats_in != total_beats || expect_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Drop the run if it hangs
    initial begin
        #TIMEOUT_NS;
        $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/seit_pkg.sv
hdl/seit_if.sv
hdl/seit_core.sv
hdl/sequenced_event_input_tracker.sv
test/testbench.sv
